// ===== rtl/core/brf_pkg.sv =====
// Shared constants, codes and beat types of the burst ring FIFO.
`default_nettype none

package brf_pkg;

   // Storage geometry and field widths.
   localparam int DEPTH      = 1024;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int SLOT_W     = IDX_W + 1;
   localparam int ELEM_WIDTH = 32;
   localparam int MAX_BURST  = 64;
   localparam int CNT_W      = 7;
   localparam int CAP_W      = 10;
   localparam int FILL_W     = 10;
   localparam int STAT_W     = 2;
   localparam int REQ_W      = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH - 1);

   // Output queue sizing; a new beat is issued only while the queue plus the
   // beat in flight through the memory read leaves a free entry.
   localparam int OUTQ_DEPTH  = 4;
   localparam int OUTQ_IDX_W  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W  = OUTQ_IDX_W + 1;
   localparam int ISSUE_LIMIT = OUTQ_DEPTH - 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_PUT_REJ = 2'd1;
   localparam logic [STAT_W-1:0] STAT_GET_REJ = 2'd2;

   // Beat descriptor issued alongside the memory read.
   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic              is_read;
      logic              last;
      logic [FILL_W-1:0] fill;
   } beat_type;

   // Finished result beat as held in the output queue.
   typedef struct packed {
      logic [STAT_W-1:0]     status;
      logic [ELEM_WIDTH-1:0] data;
      logic                  last;
      logic [FILL_W-1:0]     fill;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/burst_ring_fifo_unit.sv =====
// Top level of the burst ring FIFO: control, element store and result queue.
`default_nettype none

// A circular FIFO of up to 1023 32-bit elements whose capacity is set by the
// csr_ port (a write empties the buffer). Put beats, clears, refused gets and
// gets of zero elements each give one result beat. An admitted get of n
// elements gives n result beats with the last one marked. While the result
// channel keeps up, it holds the request channel until its last element is
// read, because its elements leave the single read port of the element store
// one per cycle. A result beat passes through the beat register and then a
// four-entry result queue. A new beat is issued only while at most two results
// are queued or in flight. A stalled result channel therefore stops new
// requests and get reads once three results are outstanding. The element store
// has no reset; every slot that can be read has been written first.
module burst_ring_fifo_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire  [brf_pkg::CAP_W-1:0]        csr_wr_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [brf_pkg::REQ_W-1:0]        req_type,
   input  wire  [brf_pkg::CNT_W-1:0]        req_burst_count,
   input  wire  [brf_pkg::ELEM_WIDTH-1:0]   req_elem_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [brf_pkg::STAT_W-1:0]       rsp_status,
   output logic [brf_pkg::ELEM_WIDTH-1:0]   rsp_out_data,
   output logic                             rsp_last_out,
   output logic [brf_pkg::FILL_W-1:0]       rsp_fill_level
);
   import brf_pkg::*;

   beat_type               beat;
   rsp_type                push_beat;
   rsp_type                head_beat;
   logic [OUTQ_CNT_W-1:0]  q_count;
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [ELEM_WIDTH-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [ELEM_WIDTH-1:0]  mem_rd_data;

   brf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_burst_count (req_burst_count),
      .req_elem_data   (req_elem_data),
      .q_count         (q_count),
      .beat            (beat),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr)
   );

   brf_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Join the beat descriptor with the element read alongside it.
   always_comb begin
      push_beat.status = beat.status;
      push_beat.data   = beat.is_read ? mem_rd_data : '0;
      push_beat.last   = beat.last;
      push_beat.fill   = beat.fill;
   end

   brf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (beat.valid),
      .push_beat (push_beat),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head_beat (head_beat)
   );

   assign rsp_status     = head_beat.status;
   assign rsp_out_data   = head_beat.data;
   assign rsp_last_out   = head_beat.last;
   assign rsp_fill_level = head_beat.fill;

   // The issue credit must keep the result queue from overflowing.
   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 1))
      else $error("result queue over its issue limit");

   // Every accepted request issues a beat in the following cycle.
   a_accept_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> beat.valid)
      else $error("accepted request produced no beat");

   // Only a read beat carries element data.
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (beat.valid && !beat.is_read) |-> (push_beat.data == '0))
      else $error("non-read beat carries data");

   // Only the elements of an admitted get arrive without the last marker.
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_out) |-> (rsp_status == STAT_OK))
      else $error("non-final beat with an error status");

endmodule

`default_nettype wire

// ===== rtl/core/brf_store.sv =====
// Element store of the ring: one write port and one registered read port.
`default_nettype none

module brf_store (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [brf_pkg::IDX_W-1:0]       wr_addr,
   input  wire  [brf_pkg::ELEM_WIDTH-1:0]  wr_data,
   input  wire                             rd_en,
   input  wire  [brf_pkg::IDX_W-1:0]       rd_addr,
   output logic [brf_pkg::ELEM_WIDTH-1:0]  rd_data
);
   import brf_pkg::*;

   logic [ELEM_WIDTH-1:0] slot_mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= slot_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/brf_outq.sv =====
// Small result queue that decouples the result channel from the control.
`default_nettype none

module brf_outq (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   input  brf_pkg::rsp_type                   push_beat,
   output logic [brf_pkg::OUTQ_CNT_W-1:0]     count,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output brf_pkg::rsp_type                   head_beat
);
   import brf_pkg::*;

   rsp_type                entry_ff [OUTQ_DEPTH];
   logic [OUTQ_IDX_W-1:0]  head_ff, head_in;
   logic [OUTQ_IDX_W-1:0]  tail_ff, tail_in;
   logic [OUTQ_CNT_W-1:0]  count_ff, count_in;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign count     = count_ff;
   assign head_beat = entry_ff[head_ff];

   // Pointer and occupancy update.
   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
// Ring index control: admits bursts, writes the store and sequences get reads.
`default_nettype none

module brf_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire  [brf_pkg::CAP_W-1:0]        csr_wr_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [brf_pkg::REQ_W-1:0]        req_type,
   input  wire  [brf_pkg::CNT_W-1:0]        req_burst_count,
   input  wire  [brf_pkg::ELEM_WIDTH-1:0]   req_elem_data,
   input  wire  [brf_pkg::OUTQ_CNT_W-1:0]   q_count,
   output brf_pkg::beat_type                beat,
   output logic                             mem_wr_en,
   output logic [brf_pkg::IDX_W-1:0]        mem_wr_addr,
   output logic [brf_pkg::ELEM_WIDTH-1:0]   mem_wr_data,
   output logic                             mem_rd_en,
   output logic [brf_pkg::IDX_W-1:0]        mem_rd_addr
);
   import brf_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_STREAM = 1'b1;

   // Step an index by one, wrapping at the slot count.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [SLOT_W-1:0] slots);
      logic [SLOT_W-1:0] sum;
      sum = {1'b0, idx} + 1'b1;
      wrap_inc = (sum == slots) ? '0 : IDX_W'(sum);
   endfunction

   logic                 state_ff, state_in;
   logic [CAP_W-1:0]     capacity_ff, capacity_in;
   logic [IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     burst_left_ff, burst_left_in;
   logic                 burst_adm_ff, burst_adm_in;
   logic [IDX_W-1:0]     stream_ptr_ff, stream_ptr_in;
   logic [CNT_W-1:0]     stream_left_ff, stream_left_in;
   logic [FILL_W-1:0]    stream_fill_ff, stream_fill_in;
   beat_type             beat_ff, beat_in;

   logic [IDX_W-1:0]     cap_eff;
   logic [SLOT_W-1:0]    slots;
   logic [IDX_W-1:0]     fill;
   logic [CNT_W-1:0]     cnt_sat;
   logic [CNT_W-1:0]     put_cnt;
   logic                 room;
   logic                 accept;
   logic                 burst_open;
   logic                 adm_now;
   logic [CNT_W-1:0]     left_now;
   logic [CNT_W-1:0]     left_after;
   logic                 write_ok;
   logic [SLOT_W-1:0]    get_sum;
   logic [IDX_W-1:0]     get_end;
   logic [IDX_W-1:0]     get_fill_after;

   // Effective capacity, slot count and current fill level.
   always_comb begin
      cap_eff = IDX_W'(capacity_ff);
      if (capacity_ff == '0) begin
         cap_eff = IDX_W'(1);
      end else if ({1'b0, capacity_ff} > (CAP_W + 1)'(DEPTH - 1)) begin
         cap_eff = IDX_W'(DEPTH - 1);
      end
      slots = {1'b0, cap_eff} + 1'b1;
      if (wr_idx_ff >= rd_idx_ff) begin
         fill = wr_idx_ff - rd_idx_ff;
      end else begin
         fill = IDX_W'(({1'b0, wr_idx_ff} + slots) - {1'b0, rd_idx_ff});
      end
   end

   // Issue credit against the result queue and input handshake.
   assign room = ({1'b0, q_count} + (OUTQ_CNT_W + 1)'(beat_ff.valid))
                 <= (OUTQ_CNT_W + 1)'(ISSUE_LIMIT);
   assign req_stall = (state_ff != ST_IDLE) || !room;
   assign accept    = req_valid && !req_stall;

   // Burst count decoding and put admission.
   always_comb begin
      cnt_sat    = (req_burst_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                         : req_burst_count;
      put_cnt    = (cnt_sat == '0) ? CNT_W'(1) : cnt_sat;
      burst_open = (burst_left_ff == '0);
      adm_now    = burst_open ? ((cap_eff - fill) >= IDX_W'(put_cnt)) : burst_adm_ff;
      left_now   = burst_open ? put_cnt : burst_left_ff;
      left_after = left_now - 1'b1;
      write_ok   = adm_now && (fill < cap_eff);
   end

   // End index and fill level of an admitted get.
   always_comb begin
      get_sum        = {1'b0, rd_idx_ff} + SLOT_W'(cnt_sat);
      get_end        = (get_sum >= slots) ? IDX_W'(get_sum - slots) : IDX_W'(get_sum);
      get_fill_after = fill - IDX_W'(cnt_sat);
   end

   // Request sequencing.
   always_comb begin
      state_in       = state_ff;
      capacity_in    = capacity_ff;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      burst_left_in  = burst_left_ff;
      burst_adm_in   = burst_adm_ff;
      stream_ptr_in  = stream_ptr_ff;
      stream_left_in = stream_left_ff;
      stream_fill_in = stream_fill_ff;
      beat_in         = '0;
      beat_in.status  = STAT_OK;
      beat_in.last    = 1'b1;
      beat_in.fill    = FILL_W'(fill);
      mem_wr_en      = 1'b0;
      mem_wr_addr    = wr_idx_ff;
      mem_wr_data    = req_elem_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rd_idx_ff;

      if (accept) begin
         beat_in.valid = 1'b1;
         case (req_type)
            REQ_PUT: begin
               mem_wr_en     = write_ok;
               burst_left_in = left_after;
               burst_adm_in  = (left_after == '0) ? 1'b0 : adm_now;
               if (write_ok) begin
                  wr_idx_in    = wrap_inc(wr_idx_ff, slots);
                  beat_in.fill = FILL_W'(fill + 1'b1);
               end else begin
                  beat_in.status = STAT_PUT_REJ;
               end
            end
            REQ_GET: begin
               if (cnt_sat == '0) begin
                  beat_in.status = STAT_OK;
               end else if (fill < IDX_W'(cnt_sat)) begin
                  beat_in.status = STAT_GET_REJ;
               end else begin
                  mem_rd_en       = 1'b1;
                  beat_in.is_read = 1'b1;
                  beat_in.last    = (cnt_sat == CNT_W'(1));
                  beat_in.fill    = FILL_W'(get_fill_after);
                  stream_ptr_in   = wrap_inc(rd_idx_ff, slots);
                  stream_left_in  = cnt_sat - 1'b1;
                  stream_fill_in  = FILL_W'(get_fill_after);
                  if (cnt_sat != CNT_W'(1)) begin
                     state_in = ST_STREAM;
                  end
                  // Draining the buffer sends both indices home.
                  if (get_fill_after == '0) begin
                     rd_idx_in = '0;
                     wr_idx_in = '0;
                  end else begin
                     rd_idx_in = get_end;
                  end
               end
            end
            REQ_CLEAR: begin
               wr_idx_in     = '0;
               rd_idx_in     = '0;
               burst_left_in = '0;
               burst_adm_in  = 1'b0;
               beat_in.fill  = '0;
            end
            default: begin
               beat_in.status = STAT_OK;
            end
         endcase
      end else if ((state_ff == ST_STREAM) && room) begin
         // Remaining elements of a get, one read per cycle while the result queue has room.
         mem_rd_en       = 1'b1;
         mem_rd_addr     = stream_ptr_ff;
         beat_in.valid   = 1'b1;
         beat_in.is_read = 1'b1;
         beat_in.last    = (stream_left_ff == CNT_W'(1));
         beat_in.fill    = stream_fill_ff;
         stream_ptr_in   = wrap_inc(stream_ptr_ff, slots);
         stream_left_in  = stream_left_ff - 1'b1;
         if (stream_left_ff == CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end

      // A capacity write empties the buffer and closes any open burst.
      if (csr_wr_en) begin
         capacity_in   = csr_wr_data;
         wr_idx_in     = '0;
         rd_idx_in     = '0;
         burst_left_in = '0;
         burst_adm_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capacity_ff   <= CAP_RESET;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         burst_left_ff <= '0;
         burst_adm_ff  <= 1'b0;
         beat_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         burst_left_ff <= burst_left_in;
         burst_adm_ff  <= burst_adm_in;
         beat_ff       <= beat_in;
      end
   end

   // Stream payload registers.
   always_ff @(posedge clock) begin
      stream_ptr_ff  <= stream_ptr_in;
      stream_left_ff <= stream_left_in;
      stream_fill_ff <= stream_fill_in;
   end

   assign beat = beat_ff;

endmodule

`default_nettype wire
